// ===== hw/rtl/e2q_pkg.sv =====
// Package: constant tables and helpers shared by the Euler-to-quaternion pipeline.
`default_nettype none
package e2q_pkg;
  localparam int AtanEntries = 24;
  localparam int AngleW = 16;
  localparam int CordW = 34;
  localparam int ZW = 33;

  function automatic logic signed [ZW-1:0] atan_val(input int idx);
    logic signed [ZW-1:0] v;
    v = '0;
    unique case (idx)
      0: v = 33'sd536870912;  1: v = 33'sd316933406;  2: v = 33'sd167458907;
      3: v = 33'sd85004756;   4: v = 33'sd42667331;   5: v = 33'sd21354465;
      6: v = 33'sd10679838;   7: v = 33'sd5340245;    8: v = 33'sd2670163;
      9: v = 33'sd1335087;    10: v = 33'sd667544;    11: v = 33'sd333772;
      12: v = 33'sd166886;    13: v = 33'sd83443;     14: v = 33'sd41722;
      15: v = 33'sd20861;     16: v = 33'sd10430;     17: v = 33'sd5215;
      18: v = 33'sd2608;      19: v = 33'sd1304;      20: v = 33'sd652;
      21: v = 33'sd326;       22: v = 33'sd163;       23: v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/e2q_cordic.sv =====
// Module: unrolled, one-step-per-stage rotation CORDIC giving sine and cosine of a half angle.
`default_nettype none
module e2q_cordic import e2q_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic signed [AngleW-1:0]      angle,
  output logic signed [FRACTION_BITS+1:0]    cos_q,
  output logic signed [FRACTION_BITS+1:0]    sin_q
);
  localparam int N = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
  localparam longint Den = 3 * (longint'(1) << (2 * N));
  localparam longint X0 = 652032874 + (2 * 652032874 + Den / 2) / Den;
  localparam int Sh = 30 - FRACTION_BITS;
  localparam int OW = FRACTION_BITS + 2;

  logic signed [CordW-1:0] x_r [N+1];
  logic signed [CordW-1:0] y_r [N+1];
  logic signed [ZW-1:0]    z_r [N+1];

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= CordW'(X0);
      y_r[0] <= '0;
      z_r[0] <= {{(ZW-AngleW-15){angle[AngleW-1]}}, angle, 15'd0};
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - atan_val(i);
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + atan_val(i);
        end
      end
    end
  end

  function automatic logic signed [OW-1:0] rnd(input logic signed [CordW-1:0] v);
    logic signed [CordW-1:0] t;
    t = (v + (CordW'(1) <<< (Sh - 1))) >>> Sh;
    if (t > (CordW'(1) <<< FRACTION_BITS)) t = CordW'(1) <<< FRACTION_BITS;
    if (t < -(CordW'(1) <<< FRACTION_BITS)) t = -(CordW'(1) <<< FRACTION_BITS);
    return t[OW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q <= rnd(x_r[N]);
      sin_q <= rnd(y_r[N]);
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/euler_to_quaternion_top.sv =====
// Top level: Euler angles (ZYX) to unit quaternion, fully pipelined.
// Channel | Dir | tdata fields (low bit first)
// in_     | in  | pitch_angle[15:0], roll_angle[31:16], yaw_angle[47:32]
// out_    | out | q_real[17:0], q_i[35:18], q_j[53:36], q_k[71:54]
// One item per cycle while out_tready does not stall the output.
// The stages are an input stage, the unrolled CORDIC stages, a rounding stage, two
// multiply stages, a sum stage and the output register.
// Stall freezes every stage at once; no item is lost or repeated.
// Reset clears the valid bits only.
`default_nettype none
module euler_to_quaternion_top import e2q_pkg::*; #(
  parameter int CORDIC_STEPS = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [47:0]                       in_tdata,  // pitch, roll, yaw
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  output logic [((4*(FRACTION_BITS+2)+7)/8)*8-1:0] out_tdata // q_real, q_i, q_j, q_k
);
  localparam int N = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;
  localparam int Lat = N + 6;
  localparam int F = FRACTION_BITS;
  localparam int OW = F + 2;
  localparam int PW = 2 * OW;
  localparam int TW = ((4 * OW + 7) / 8) * 8;

  logic en;
  logic [Lat-1:0] vld_r;
  assign en = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[Lat-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_tvalid};
    end
  end

  logic signed [OW-1:0] cp, sp, cr, sr, cy, sy;
  e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(F)) u_p (
    .clk(clk), .en(en), .angle(in_tdata[15:0]), .cos_q(cp), .sin_q(sp));
  e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(F)) u_r (
    .clk(clk), .en(en), .angle(in_tdata[31:16]), .cos_q(cr), .sin_q(sr));
  e2q_cordic #(.CORDIC_STEPS(CORDIC_STEPS), .FRACTION_BITS(F)) u_y (
    .clk(clk), .en(en), .angle(in_tdata[47:32]), .cos_q(cy), .sin_q(sy));

  function automatic logic signed [OW-1:0] mul_r(input logic signed [OW-1:0] a,
                                                 input logic signed [OW-1:0] b);
    logic signed [PW-1:0] p;
    p = (PW'(a) * PW'(b) + (PW'(1) <<< (F - 1))) >>> F;
    return p[OW-1:0];
  endfunction

  logic signed [OW-1:0] cc_r, ss_r, sc_r, cs_r, cy_r, sy_r;
  logic signed [PW-1:0] p_r [8];
  logic signed [PW:0]   s_r [4];
  logic [TW-1:0] od_r;

  function automatic logic [OW-1:0] fin(input logic signed [PW:0] v);
    logic signed [PW:0] t;
    t = (v + ((PW+1)'(1) <<< (F - 1))) >>> F;
    if (t > ((PW+1)'(1) <<< F)) t = (PW+1)'(1) <<< F;
    if (t < -((PW+1)'(1) <<< F)) t = -((PW+1)'(1) <<< F);
    return t[OW-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      cc_r <= mul_r(cr, cp);
      ss_r <= mul_r(sr, sp);
      sc_r <= mul_r(sr, cp);
      cs_r <= mul_r(cr, sp);
      cy_r <= cy;
      sy_r <= sy;
      p_r[0] <= PW'(cc_r) * PW'(cy_r);
      p_r[1] <= PW'(ss_r) * PW'(sy_r);
      p_r[2] <= PW'(sc_r) * PW'(cy_r);
      p_r[3] <= PW'(cs_r) * PW'(sy_r);
      p_r[4] <= PW'(cs_r) * PW'(cy_r);
      p_r[5] <= PW'(sc_r) * PW'(sy_r);
      p_r[6] <= PW'(cc_r) * PW'(sy_r);
      p_r[7] <= PW'(ss_r) * PW'(cy_r);
      s_r[0] <= (PW+1)'(p_r[0]) + (PW+1)'(p_r[1]);
      s_r[1] <= (PW+1)'(p_r[2]) - (PW+1)'(p_r[3]);
      s_r[2] <= (PW+1)'(p_r[4]) + (PW+1)'(p_r[5]);
      s_r[3] <= (PW+1)'(p_r[6]) - (PW+1)'(p_r[7]);
      od_r <= TW'({fin(s_r[3]), fin(s_r[2]), fin(s_r[1]), fin(s_r[0])});
    end
  end
  assign out_tdata = od_r;
endmodule
`default_nettype wire

// ===== hw/rtl/e2q_checker.sv =====
// Checker: port-level properties of the quaternion pipeline, bound to the top level.
`default_nettype none
module e2q_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [71:0] out_tdata
);
  a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready) else $error("ready while stalled");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("drop");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid) else $error("reset");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[17] == 1'b0 && out_tdata[16] == 1'b1 && out_tdata[15:0] != 16'd0))
    else $error("range");
endmodule
bind euler_to_quaternion_top e2q_checker u_chk (.clk(clk), .rst_n(rst_n),
  .in_tready(in_tready), .out_tvalid(out_tvalid),
  .out_tready(out_tready), .out_tdata(out_tdata));
`default_nettype wire
